[src/crng_pkg.sv]
// ----------------------------------------------------------------------------
// crng_pkg
// Shared constants and types of the combined LCG generator with shuffle table.
// ----------------------------------------------------------------------------
package crng_pkg;

    typedef logic [30:0] word_t;

    // Moduli are 2^31 - 85 and 2^31 - 249, so 2^31 folds back as 85 or 249
    localparam word_t       MOD_A        = 31'd2147483563;
    localparam word_t       MOD_B        = 31'd2147483399;
    localparam logic [15:0] MUL_A        = 16'd40014;
    localparam logic [15:0] MUL_B        = 16'd40692;
    localparam logic [7:0]  FOLD_A       = 8'd85;
    localparam logic [7:0]  FOLD_B       = 8'd249;
    localparam word_t       SEED_B_RESET = 31'd123456789;
    localparam word_t       WRAP_ADD     = 31'd2147483562;

    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef struct packed {
        logic load;   // load both generators with the seed
        logic start;  // begin one modular step
        logic both;   // step the second generator too
    } gen_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_WARM_ISSUE = 5'b00010,
        ST_WARM_WAIT  = 5'b00100,
        ST_STEP       = 5'b01000,
        ST_READ       = 5'b10000
    } state_t;

endpackage

[src/crng_gen.sv]
// ----------------------------------------------------------------------------
// crng_gen
// Both multiplicative generators: multiply, fold by 2^31, reduce.
// ----------------------------------------------------------------------------
module crng_gen
    import crng_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gen_cmd_t cmd,
    input  word_t    seed,
    output logic     done,
    output word_t    g1,
    output word_t    g2
);

    word_t       g1_reg, g1_next;
    word_t       g2_reg, g2_next;
    logic [46:0] prod_a_reg, prod_a_next;
    logic [46:0] prod_b_reg, prod_b_next;
    logic [31:0] fold_a_reg, fold_a_next;
    logic [31:0] fold_b_reg, fold_b_next;
    logic        v1_reg, v2_reg, done_reg;
    logic        both_reg;
    word_t       red_a, red_b;

    always_comb
    begin
        prod_a_next = {16'd0, g1_reg} * {31'd0, MUL_A};
        prod_b_next = {16'd0, g2_reg} * {31'd0, MUL_B};
        fold_a_next = {1'b0, prod_a_reg[30:0]} + {16'd0, prod_a_reg[46:31]} * {24'd0, FOLD_A};
        fold_b_next = {1'b0, prod_b_reg[30:0]} + {16'd0, prod_b_reg[46:31]} * {24'd0, FOLD_B};
        // folded sum stays below twice the modulus
        red_a = (fold_a_reg >= {1'b0, MOD_A}) ? 31'(fold_a_reg - {1'b0, MOD_A})
                                               : fold_a_reg[30:0];
        red_b = (fold_b_reg >= {1'b0, MOD_B}) ? 31'(fold_b_reg - {1'b0, MOD_B})
                                               : fold_b_reg[30:0];
        g1_next = g1_reg;
        g2_next = g2_reg;
        if (cmd.load)
        begin
            g1_next = (seed == '0) ? 31'd1 : seed;
            g2_next = g1_next;
        end
        else if (v2_reg)
        begin
            g1_next = red_a;
            if (both_reg)
            begin
                g2_next = red_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg   <= 31'd1;
            g2_reg   <= SEED_B_RESET;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            both_reg <= 1'b0;
        end
        else
        begin
            g1_reg   <= g1_next;
            g2_reg   <= g2_next;
            v1_reg   <= cmd.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            if (cmd.start)
            begin
                both_reg <= cmd.both;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        fold_a_reg <= fold_a_next;
        fold_b_reg <= fold_b_next;
    end

    assign done = done_reg;
    assign g1   = g1_reg;
    assign g2   = g2_reg;

endmodule

[src/crng_idxdiv.sv]
// ----------------------------------------------------------------------------
// crng_idxdiv
// Table index from the last output: reciprocal multiply by the constant.
// ----------------------------------------------------------------------------
module crng_idxdiv
    import crng_pkg::*;
#(
    parameter  int TABLE_DEPTH = 32,
    localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  word_t         x,
    output logic          done,
    output logic [IW-1:0] idx
);

    // rounded-up reciprocal: its error times any 31-bit dividend stays below
    // one step of the shift, so the quotient is exact
    localparam longint unsigned DIVISOR = 1 + (64'(MOD_A) - 1) / TABLE_DEPTH;
    localparam int              LOG_D   = $clog2(DIVISOR);
    localparam int              SHIFT   = 31 + LOG_D;
    localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [31:0]     RECIP_W = 32'(RECIP);

    word_t       x_reg, x_next;
    logic [62:0] prod_reg, prod_next;
    logic [62:0] quo;
    logic        v_reg, done_reg;

    always_comb
    begin
        x_next    = start ? x : x_reg;
        // hold the product until the next transaction
        prod_next = v_reg ? {32'd0, x_reg} * {31'd0, RECIP_W} : prod_reg;
        quo       = prod_reg >> SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= start;
            done_reg <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
    end

    // guard: clamp to the last entry
    assign idx  = (quo >= 63'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH - 1) : quo[IW-1:0];
    assign done = done_reg;

endmodule

[src/crng_table.sv]
// ----------------------------------------------------------------------------
// crng_table
// Shuffle table: one write port, one registered read port, per-entry valid.
// ----------------------------------------------------------------------------
module crng_table
    import crng_pkg::*;
#(
    parameter  int TABLE_DEPTH = 32,
    localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output word_t         rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  word_t         wr_data
);

    word_t                  mem [TABLE_DEPTH];
    word_t                  q_reg;
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic                   rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rvld_reg ? q_reg : '0;

endmodule

[src/combined_lcg_shuffle_rng.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-LCG generator with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
//  channel  | signals                    | transfer
//  ---------+----------------------------+----------------------------------
//  request  | start, busy, op, seed_value| start high while busy low
//  result   | done, random_value         | done high one cycle, no backpressure
//
//  A next request strobes its result after the modular multiply, then the
//  table read and write-back; the index multiply runs alongside.
//  A reseed first loads the generators and runs TABLE_DEPTH + 8 warm-up steps,
//  filling the table.
//  Reset empties the table (entries read as zero) and restores the generators.
//  The result strobe may coincide with acceptance of the next request.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
    import crng_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  logic  op,
    input  word_t seed_value,
    output logic  done,
    output word_t random_value
);

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WCW = $clog2(TABLE_DEPTH + 9);

    state_t         state_reg, state_next;
    word_t          last_reg, last_next;
    logic [WCW-1:0] warm_cnt_reg, warm_cnt_next;
    logic [WCW-1:0] warm_idx;
    logic           gen_ok_reg, gen_ok_next;
    logic           div_ok_reg, div_ok_next;
    logic           done_reg, done_next;
    word_t          rv_reg, rv_next;

    gen_cmd_t       gen_cmd;
    logic           gen_done;
    word_t          g1, g2;
    logic           div_start;
    word_t          div_x;
    logic           div_done;
    logic [IW-1:0]  div_idx;
    logic           tbl_re, tbl_we;
    logic [IW-1:0]  tbl_waddr;
    word_t          tbl_rdata, tbl_wdata;
    logic [31:0]    diff, wrapped;

    crng_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (gen_cmd),
        .seed  (seed_value),
        .done  (gen_done),
        .g1    (g1),
        .g2    (g2)
    );

    crng_idxdiv #(.TABLE_DEPTH(TABLE_DEPTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (div_x),
        .done  (div_done),
        .idx   (div_idx)
    );

    crng_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_tbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_re),
        .rd_addr (div_idx),
        .rd_data (tbl_rdata),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign warm_idx = warm_cnt_reg - WCW'(1);

    always_comb
    begin
        diff    = {1'b0, tbl_rdata} - {1'b0, g2};
        wrapped = (diff[31] || diff == '0) ? diff + {1'b0, WRAP_ADD} : diff;

        state_next    = state_reg;
        last_next     = last_reg;
        warm_cnt_next = warm_cnt_reg;
        gen_ok_next   = gen_ok_reg;
        div_ok_next   = div_ok_reg;
        done_next     = 1'b0;
        rv_next       = rv_reg;
        gen_cmd       = '0;
        div_start     = 1'b0;
        div_x         = last_reg;
        tbl_re        = 1'b0;
        tbl_we        = 1'b0;
        tbl_waddr     = div_idx;
        tbl_wdata     = g1;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_SEED)
                    begin
                        gen_cmd.load  = 1'b1;
                        warm_cnt_next = WCW'(TABLE_DEPTH + 8);
                        state_next    = ST_WARM_ISSUE;
                    end
                    else
                    begin
                        gen_cmd.start = 1'b1;
                        gen_cmd.both  = 1'b1;
                        div_start     = 1'b1;
                        state_next    = ST_STEP;
                    end
                end
            end
            ST_WARM_ISSUE:
            begin
                gen_cmd.start = 1'b1;
                state_next    = ST_WARM_WAIT;
            end
            ST_WARM_WAIT:
            begin
                if (gen_done)
                begin
                    // fill the table on the last TABLE_DEPTH warm-up steps
                    tbl_we        = (warm_cnt_reg <= WCW'(TABLE_DEPTH));
                    tbl_waddr     = warm_idx[IW-1:0];
                    warm_cnt_next = warm_idx;
                    gen_cmd.start = 1'b1;
                    if (warm_cnt_reg == WCW'(1))
                    begin
                        // entry zero is the last output; go on with a plain step
                        last_next    = g1;
                        gen_cmd.both = 1'b1;
                        div_start    = 1'b1;
                        div_x        = g1;
                        state_next   = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if ((gen_ok_reg || gen_done) && (div_ok_reg || div_done))
                begin
                    tbl_re      = 1'b1;
                    gen_ok_next = 1'b0;
                    div_ok_next = 1'b0;
                    state_next  = ST_READ;
                end
                else
                begin
                    gen_ok_next = gen_ok_reg || gen_done;
                    div_ok_next = div_ok_reg || div_done;
                end
            end
            ST_READ:
            begin
                tbl_we     = 1'b1;
                rv_next    = wrapped[30:0];
                last_next  = wrapped[30:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_reg     <= '0;
            warm_cnt_reg <= '0;
            gen_ok_reg   <= 1'b0;
            div_ok_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            warm_cnt_reg <= warm_cnt_next;
            gen_ok_reg   <= gen_ok_next;
            div_ok_reg   <= div_ok_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg <= rv_next;
    end

    assign done         = done_reg;
    assign random_value = rv_reg;

    // a result only follows the table read state
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_READ))
        else $error("result strobe without table read");

    // outputs never reach zero after wrapping
    a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> random_value != '0)
        else $error("zero random value");

    // the table is only written while a transaction is in progress
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> busy)
        else $error("table write while idle");

    // an accepted transaction always raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

endmodule
